>>> src/bnb_pkg.sv
// Shared constants and codes for the batch-norm backward channel block.
package bnb_pkg;

  // Digit width of the shared serial multiplier.
  localparam int DIGIT_W = 16;

  // Fixed register and field widths.
  localparam int INV_STD_W = 16;
  localparam int INV_CNT_W = 25;
  localparam int RS2_W     = 2 * INV_STD_W;
  localparam int GIN_W     = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Rounding shifts of the fixed-point scalings.
  localparam int SH_GG  = 20;
  localparam int SH_PRD = 8;
  localparam int SH_SQ  = 24;
  localparam int SH_CNT = 24;
  localparam int SH_DX  = 12;

  // Register reset values.
  localparam int GAMMA_RESET     = 256;
  localparam int MEAN_RESET      = 0;
  localparam int INV_STD_RESET   = 4096;
  localparam int INV_COUNT_RESET = 16777216;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_EMIT  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAMMA     = 2'd0,
    REG_MEAN      = 2'd1,
    REG_INV_STD   = 2'd2,
    REG_INV_COUNT = 2'd3
  } cfg_reg_t;

endpackage

>>> src/bnb_cfg.sv
// Configuration register file of the batch-norm backward channel block.
module bnb_cfg #(
  parameter int DATA_WIDTH = 16,
  parameter int CFG_W      = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bnb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  output logic signed [DATA_WIDTH-1:0]   gamma_value,
  output logic signed [DATA_WIDTH-1:0]   mean_value,
  output logic [bnb_pkg::INV_STD_W-1:0]  inv_std,
  output logic [bnb_pkg::INV_CNT_W-1:0]  inv_count
);
  import bnb_pkg::*;

  // Each register keeps only its own low bits of the written word.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_value <= DATA_WIDTH'(GAMMA_RESET);
      mean_value  <= DATA_WIDTH'(MEAN_RESET);
      inv_std     <= INV_STD_W'(INV_STD_RESET);
      inv_count   <= INV_CNT_W'(INV_COUNT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA:     gamma_value <= cfg_wdata[DATA_WIDTH-1:0];
        REG_MEAN:      mean_value  <= cfg_wdata[DATA_WIDTH-1:0];
        REG_INV_STD:   inv_std     <= cfg_wdata[INV_STD_W-1:0];
        REG_INV_COUNT: inv_count   <= cfg_wdata[INV_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/bnb_mul.sv
// Shared digit-serial signed multiplier, one digit of the first operand per cycle.
module bnb_mul #(
  parameter int XW = 48,
  parameter int KW = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [XW-1:0]    x_op,
  input  logic signed [KW-1:0]    k_op,
  output logic                    done,
  output logic signed [XW+KW-1:0] product
);
  import bnb_pkg::*;

  localparam int PW    = XW + KW;
  localparam int ND    = XW / DIGIT_W;
  localparam int CNT_W = $clog2(ND + 1);
  localparam int PPW   = DIGIT_W + 1 + KW;

  logic [XW-1:0]           shreg;
  logic signed [KW-1:0]    k_r;
  logic [CNT_W-1:0]        cnt;
  logic                    first;
  logic signed [DIGIT_W:0] digit;
  logic signed [PPW-1:0]   partial;
  logic signed [PW-1:0]    product_next;

  // Digits go most significant first; only the top digit carries the sign.
  assign digit        = {first & shreg[XW-1], shreg[XW-1 -: DIGIT_W]};
  assign partial      = digit * k_r;
  assign product_next = (product <<< DIGIT_W) + PW'(partial);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      first <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= CNT_W'(ND);
        first <= 1'b1;
      end else if (cnt != '0) begin
        cnt   <= cnt - 1'b1;
        first <= 1'b0;
        done  <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= x_op;
      k_r     <= k_op;
      product <= '0;
    end else if (cnt != '0) begin
      shreg   <= shreg << DIGIT_W;
      product <= product_next;
    end
  end

endmodule

>>> src/batch_norm_backward_channel_top.sv
// Top level of the batch-norm backward channel block: handshake, sequencer and sums.
//
// One beat in gives one beat out. A beat carries a command (clear, accumulate or
// emit), the output gradient and the forward input. Clear zeroes the four sums
// and answers the next cycle; the unused command code changes nothing and also
// answers the next cycle. Accumulate and emit run a chain of multiplications on
// one shared digit-serial multiplier that consumes one 16-bit digit of its first
// operand per cycle. Each multiplication pass loads the operands, works through the
// ND digits and then hands the product back, where ND is the number of 16-bit
// digits in max(ACC_WIDTH, 2*DATA_WIDTH+1) (ND = 3 by default). Each rounded
// scaling takes two passes, one for the integer part and one for the fraction.
// Accumulate needs nine passes and emit seven. The block takes no new beat until
// its result beat has been taken, and it is ready again in the cycle after that.
// The result beat holds grad_in (zero unless emit) and the dgamma and dbeta sums
// as they stand after the beat. All sums saturate at the signed ACC_WIDTH range
// and grad_in saturates at 32 bits. Configuration writes take effect at once and
// must be made while no beat is in flight.
module batch_norm_backward_channel_top #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic clk,
  input  logic rst,
  // Input stream.
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // s_tdata, from bit 0 up: grad_out, x_value, zero padding.
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
  // s_tuser: command.
  input  logic [bnb_pkg::CMD_W-1:0]                    s_tuser,
  // Result stream.
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // m_tdata, from bit 0 up: grad_in, grad_gamma_sum, grad_beta_sum, zero padding.
  output logic [((bnb_pkg::GIN_W+2*ACC_WIDTH+7)/8)*8-1:0] m_tdata,
  // Configuration write port.
  input  logic                                         cfg_we,
  input  logic [bnb_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [(DATA_WIDTH > bnb_pkg::INV_CNT_W ? DATA_WIDTH
                 : bnb_pkg::INV_CNT_W)-1:0]            cfg_wdata
);
  import bnb_pkg::*;

  localparam int CFG_W  = (DATA_WIDTH > INV_CNT_W) ? DATA_WIDTH : INV_CNT_W;
  localparam int OUT_TW = ((GIN_W + 2 * ACC_WIDTH + 7) / 8) * 8;
  localparam int DW1    = DATA_WIDTH + 1;
  localparam int AW1    = ACC_WIDTH + 1;
  // Widest first operand: a sum, or the raw product of gradient and centered input.
  localparam int VW     = (ACC_WIDTH > 2 * DATA_WIDTH + 1) ? ACC_WIDTH : 2 * DATA_WIDTH + 1;
  localparam int ND     = (VW + DIGIT_W - 1) / DIGIT_W;
  localparam int XW     = ND * DIGIT_W;
  // Widest second operand: the squared reciprocal deviation or the centered input.
  localparam int KW     = (DW1 > RS2_W + 1) ? DW1 : RS2_W + 1;
  localparam int PW     = XW + KW;
  localparam int SHW    = 5;

  localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AMIN = ~AMAX;
  localparam logic signed [PW-1:0] AMAX_P = {{(PW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] AMIN_P = ~AMAX_P;
  localparam logic signed [ACC_WIDTH-1:0] I32MAX = {{(ACC_WIDTH-GIN_W+1){1'b0}},
                                                    {(GIN_W-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] I32MIN = ~I32MAX;

  // Sequencer steps; the _A step of a rounded scaling forms the integer part
  // times the factor, the _B step the fraction times the factor.
  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_DXH   = 17'h00002,
    ST_DW    = 17'h00004,
    ST_GG_A  = 17'h00008,
    ST_GG_B  = 17'h00010,
    ST_PRD_A = 17'h00020,
    ST_PRD_B = 17'h00040,
    ST_RS2   = 17'h00080,
    ST_SQ_A  = 17'h00100,
    ST_SQ_B  = 17'h00200,
    ST_CEN_A = 17'h00400,
    ST_CEN_B = 17'h00800,
    ST_CNT_A = 17'h01000,
    ST_CNT_B = 17'h02000,
    ST_DX_A  = 17'h04000,
    ST_DX_B  = 17'h08000,
    ST_OUT   = 17'h10000
  } state_t;

  state_t state;
  logic   issued;

  logic signed [DATA_WIDTH-1:0] gamma_value;
  logic signed [DATA_WIDTH-1:0] mean_value;
  logic [INV_STD_W-1:0]         inv_std;
  logic [INV_CNT_W-1:0]         inv_count;

  logic signed [DATA_WIDTH-1:0] grad_out;
  logic signed [DATA_WIDTH-1:0] x_value;

  // Item registers.
  logic [CMD_W-1:0]             cmd_r;
  logic signed [DATA_WIDTH-1:0] dout_r;
  logic signed [DW1-1:0]        d_r;

  // Running sums.
  logic signed [ACC_WIDTH-1:0]  gsum;
  logic signed [ACC_WIDTH-1:0]  bsum;
  logic signed [ACC_WIDTH-1:0]  csum;
  logic signed [ACC_WIDTH-1:0]  ssum;

  // Intermediate values.
  logic signed [ACC_WIDTH-1:0]  dxh;
  logic signed [ACC_WIDTH-1:0]  tg;
  logic signed [XW-1:0]         src;
  logic signed [PW-1:0]         pr;
  logic [RS2_W-1:0]             rs2;
  logic signed [GIN_W-1:0]      gin;

  // Multiplier hookup.
  logic                  mul_state;
  logic                  rnd_state;
  logic                  b_pass;
  logic                  mul_start;
  logic                  mul_done;
  logic signed [XW-1:0]  x_op;
  logic signed [KW-1:0]  k_op;
  logic signed [PW-1:0]  mul_p;
  logic [SHW-1:0]        rnd_n;
  logic signed [XW-1:0]  x_a;
  logic [XW-1:0]         low_mask;
  logic signed [PW-1:0]  half;
  logic signed [PW-1:0]  lo;
  logic signed [PW-1:0]  rsum;
  logic signed [ACC_WIDTH-1:0] rnd;

  function automatic logic signed [ACC_WIDTH-1:0] clamp_p(input logic signed [PW-1:0] v);
    if (v > AMAX_P) begin
      return AMAX;
    end else if (v < AMIN_P) begin
      return AMIN;
    end
    return v[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_fit(input logic signed [AW1-1:0] s);
    if (s[AW1-1] != s[AW1-2]) begin
      return s[AW1-1] ? AMIN : AMAX;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [ACC_WIDTH-1:0] b
  );
    return sat_fit(AW1'(a) + AW1'(b));
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_sub(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [ACC_WIDTH-1:0] b
  );
    return sat_fit(AW1'(a) - AW1'(b));
  endfunction

  function automatic logic signed [GIN_W-1:0] clamp32(input logic signed [ACC_WIDTH-1:0] v);
    if (v > I32MAX) begin
      return I32MAX[GIN_W-1:0];
    end else if (v < I32MIN) begin
      return I32MIN[GIN_W-1:0];
    end
    return v[GIN_W-1:0];
  endfunction

  bnb_cfg #(
    .DATA_WIDTH (DATA_WIDTH),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .gamma_value (gamma_value),
    .mean_value  (mean_value),
    .inv_std     (inv_std),
    .inv_count   (inv_count)
  );

  bnb_mul #(
    .XW (XW),
    .KW (KW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x_op    (x_op),
    .k_op    (k_op),
    .done    (mul_done),
    .product (mul_p)
  );

  assign grad_out = s_tdata[DATA_WIDTH-1:0];
  assign x_value  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = OUT_TW'({bsum, gsum, gin});

  // Operand selection for the current step. A rounded scaling of v by k splits
  // v into floor(v / 2^n) and its n-bit remainder; each goes through the
  // multiplier on its own so that overflow of the integer part is seen exactly.
  always_comb begin
    x_op      = '0;
    k_op      = '0;
    rnd_n     = SHW'(SH_PRD);
    mul_state = 1'b1;
    rnd_state = 1'b1;
    b_pass    = 1'b0;
    case (state)
      ST_DXH: begin
        x_op      = XW'(dout_r);
        k_op      = KW'(gamma_value);
        rnd_state = 1'b0;
      end
      ST_DW: begin
        x_op      = XW'(dout_r);
        k_op      = KW'(d_r);
        rnd_state = 1'b0;
      end
      ST_RS2: begin
        x_op      = XW'(inv_std);
        k_op      = KW'(inv_std);
        rnd_state = 1'b0;
      end
      ST_GG_A, ST_GG_B: begin
        k_op   = KW'(inv_std);
        rnd_n  = SHW'(SH_GG);
        b_pass = (state == ST_GG_B);
      end
      ST_PRD_A, ST_PRD_B: begin
        k_op   = KW'(d_r);
        rnd_n  = SHW'(SH_PRD);
        b_pass = (state == ST_PRD_B);
      end
      ST_SQ_A, ST_SQ_B: begin
        k_op   = KW'(rs2);
        rnd_n  = SHW'(SH_SQ);
        b_pass = (state == ST_SQ_B);
      end
      ST_CEN_A, ST_CEN_B: begin
        k_op   = KW'(d_r);
        rnd_n  = SHW'(SH_PRD);
        b_pass = (state == ST_CEN_B);
      end
      ST_CNT_A, ST_CNT_B: begin
        k_op   = KW'(inv_count);
        rnd_n  = SHW'(SH_CNT);
        b_pass = (state == ST_CNT_B);
      end
      ST_DX_A, ST_DX_B: begin
        k_op   = KW'(inv_std);
        rnd_n  = SHW'(SH_DX);
        b_pass = (state == ST_DX_B);
      end
      default: begin
        mul_state = 1'b0;
        rnd_state = 1'b0;
      end
    endcase
    if (rnd_state) begin
      x_op = b_pass ? XW'(XW'(src) & low_mask) : x_a;
    end
  end

  assign x_a       = src >>> rnd_n;
  assign low_mask  = ~({XW{1'b1}} << rnd_n);
  assign mul_start = mul_state & ~issued;

  // Combine the integer-part product held in pr with the fraction product from
  // the multiplier, rounding half up. An integer-part product whose magnitude
  // reaches 2^(ACC_WIDTH-1) saturates by its own sign, whatever the fraction adds.
  assign half = PW'(1) << (rnd_n - SHW'(1));
  assign lo   = (mul_p + half) >>> rnd_n;
  assign rsum = pr + lo;

  always_comb begin
    if (pr > AMAX_P) begin
      rnd = AMAX;
    end else if (pr <= AMIN_P) begin
      rnd = AMIN;
    end else begin
      rnd = clamp_p(rsum);
    end
  end

  // Control state and the sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
      gsum   <= '0;
      bsum   <= '0;
      csum   <= '0;
      ssum   <= '0;
    end else begin
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (s_tuser)
              CMD_CLEAR: begin
                gsum  <= '0;
                bsum  <= '0;
                csum  <= '0;
                ssum  <= '0;
                state <= ST_OUT;
              end
              CMD_ACCUM, CMD_EMIT: state <= ST_DXH;
              default:             state <= ST_OUT;
            endcase
          end
        end
        ST_DXH: begin
          if (mul_done) begin
            state <= (cmd_r == CMD_ACCUM) ? ST_DW : ST_CEN_A;
          end
        end
        ST_DW:    if (mul_done) state <= ST_GG_A;
        ST_GG_A:  if (mul_done) state <= ST_GG_B;
        ST_GG_B:  if (mul_done) state <= ST_PRD_A;
        ST_PRD_A: if (mul_done) state <= ST_PRD_B;
        ST_PRD_B: if (mul_done) state <= ST_RS2;
        ST_RS2:   if (mul_done) state <= ST_SQ_A;
        ST_SQ_A:  if (mul_done) state <= ST_SQ_B;
        ST_SQ_B: begin
          if (mul_done) begin
            gsum  <= sat_add(gsum, tg);
            bsum  <= sat_add(bsum, ACC_WIDTH'(dout_r));
            csum  <= sat_add(csum, rnd);
            ssum  <= sat_add(ssum, dxh);
            state <= ST_OUT;
          end
        end
        ST_CEN_A: if (mul_done) state <= ST_CEN_B;
        ST_CEN_B: if (mul_done) state <= ST_CNT_A;
        ST_CNT_A: if (mul_done) state <= ST_CNT_B;
        ST_CNT_B: if (mul_done) state <= ST_DX_A;
        ST_DX_A:  if (mul_done) state <= ST_DX_B;
        ST_DX_B:  if (mul_done) state <= ST_OUT;
        ST_OUT:   if (m_tready) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Item and intermediate registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_r  <= s_tuser;
          dout_r <= grad_out;
          d_r    <= DW1'(x_value) - DW1'(mean_value);
          gin    <= '0;
        end
      end
      ST_DXH: begin
        if (mul_done) begin
          dxh <= clamp_p(mul_p);
          src <= XW'(csum);
        end
      end
      ST_DW: begin
        if (mul_done) begin
          src <= mul_p[XW-1:0];
        end
      end
      ST_GG_A, ST_PRD_A, ST_SQ_A, ST_CEN_A, ST_CNT_A, ST_DX_A: begin
        if (mul_done) begin
          pr <= mul_p;
        end
      end
      ST_GG_B: begin
        if (mul_done) begin
          tg  <= rnd;
          src <= XW'(dxh);
        end
      end
      ST_PRD_B: begin
        if (mul_done) begin
          src <= XW'(rnd);
        end
      end
      ST_RS2: begin
        if (mul_done) begin
          rs2 <= mul_p[RS2_W-1:0];
        end
      end
      ST_CEN_B: begin
        if (mul_done) begin
          src <= XW'(sat_add(rnd, ssum));
        end
      end
      ST_CNT_B: begin
        if (mul_done) begin
          src <= XW'(sat_sub(dxh, rnd));
        end
      end
      ST_DX_B: begin
        if (mul_done) begin
          gin <= clamp32(rnd);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> tb/bnb_checker.sv
// Result checker for the batch-norm backward channel block: predicts every result beat.
module bnb_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48,
  parameter int S_W        = ((2*DATA_WIDTH+7)/8)*8,
  parameter int M_W        = ((bnb_pkg::GIN_W+2*ACC_WIDTH+7)/8)*8,
  parameter int CFG_W      = (DATA_WIDTH > bnb_pkg::INV_CNT_W) ? DATA_WIDTH
                             : bnb_pkg::INV_CNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [S_W-1:0]                s_tdata,
  input  logic [bnb_pkg::CMD_W-1:0]     s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [M_W-1:0]                m_tdata,
  input  logic                          cfg_we,
  input  logic [bnb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata,
  output int unsigned                   outstanding,
  output int unsigned                   mismatches,
  output int unsigned                   checked
);
  import bnb_pkg::*;

  localparam longint ACC_MAX = (longint'(1) <<< (ACC_WIDTH-1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint GIN_MAX = (longint'(1) <<< (GIN_W-1)) - 1;
  localparam longint GIN_MIN = -GIN_MAX - 1;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] beta_sum;
    logic [ACC_WIDTH-1:0] gamma_sum;
    logic [GIN_W-1:0]     grad_in;
  } bn_result_t;

  // Channel configuration and the four running sums, as the block should hold them.
  longint gamma_r, mean_r, rstd_r, rcount_r;
  longint dgamma_sum, dbeta_sum, centered_sum, scaled_sum;

  bn_result_t expected_q[$];

  function automatic longint acc_clamp(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // round(v*k / 2^n) with ties toward +inf, saturated; v is split into an integer
  // part and an n-bit fraction so the products stay inside 64 bits.
  function automatic longint scale_round(longint v, longint k, int n);
    longint ip, fp, lo, hi;
    longint unsigned am, km;
    ip = v >>> n;
    fp = v - (ip <<< n);
    lo = (fp * k + (longint'(1) <<< (n-1))) >>> n;
    hi = 0;
    if (ip != 0 && k != 0) begin
      am = (ip < 0) ? -ip : ip;
      km = (k < 0) ? -k : k;
      if (am > longint'(ACC_MAX) / km) return ((ip < 0) != (k < 0)) ? ACC_MIN : ACC_MAX;
      hi = ip * k;
    end
    return acc_clamp(hi + lo);
  endfunction

  function automatic void clear_sums();
    dgamma_sum   = 0;
    dbeta_sum    = 0;
    centered_sum = 0;
    scaled_sum   = 0;
  endfunction

  // Advances the sums by one input beat and returns the result beat it must cause.
  function automatic bn_result_t grad_step(logic [CMD_W-1:0] cmd, logic [S_W-1:0] data);
    longint dout, xv, d, dxh, tg, t1, tc, t, s, m, q, r;
    bn_result_t res;
    dout = longint'($signed(data[DATA_WIDTH-1:0]));
    xv   = longint'($signed(data[2*DATA_WIDTH-1:DATA_WIDTH]));
    d    = xv - mean_r;
    dxh  = acc_clamp(dout * gamma_r);
    r    = 0;
    case (cmd)
      CMD_CLEAR: clear_sums();
      CMD_ACCUM: begin
        tg = scale_round(dout * d, rstd_r, SH_GG);
        t1 = scale_round(dxh, d, SH_PRD);
        tc = scale_round(t1, rstd_r * rstd_r, SH_SQ);
        dgamma_sum   = acc_clamp(dgamma_sum + tg);
        dbeta_sum    = acc_clamp(dbeta_sum + dout);
        centered_sum = acc_clamp(centered_sum + tc);
        scaled_sum   = acc_clamp(scaled_sum + dxh);
      end
      CMD_EMIT: begin
        t = scale_round(centered_sum, d, SH_PRD);
        s = acc_clamp(t + scaled_sum);
        m = scale_round(s, rcount_r, SH_CNT);
        q = acc_clamp(dxh - m);
        r = scale_round(q, rstd_r, SH_DX);
        if (r > GIN_MAX) r = GIN_MAX;
        if (r < GIN_MIN) r = GIN_MIN;
      end
      default: ;
    endcase
    res.grad_in   = r[GIN_W-1:0];
    res.gamma_sum = dgamma_sum[ACC_WIDTH-1:0];
    res.beta_sum  = dbeta_sum[ACC_WIDTH-1:0];
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("bnb_checker: result %0d %s: got %0d, expected %0d", checked, what, got, want);
  endtask

  always @(posedge clk) begin
    bn_result_t got, want;
    if (rst) begin
      gamma_r  = GAMMA_RESET;
      mean_r   = MEAN_RESET;
      rstd_r   = INV_STD_RESET;
      rcount_r = INV_COUNT_RESET;
      clear_sums();
      expected_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[GIN_W+2*ACC_WIDTH-1:0];
        if (expected_q.size() == 0) begin
          report("unexpected beat, grad_in", longint'($signed(got.grad_in)), 0);
        end else begin
          want = expected_q.pop_front();
          if (got.grad_in !== want.grad_in)
            report("grad_in", longint'($signed(got.grad_in)),
                   longint'($signed(want.grad_in)));
          if (got.gamma_sum !== want.gamma_sum)
            report("grad_gamma_sum", longint'($signed(got.gamma_sum)),
                   longint'($signed(want.gamma_sum)));
          if (got.beta_sum !== want.beta_sum)
            report("grad_beta_sum", longint'($signed(got.beta_sum)),
                   longint'($signed(want.beta_sum)));
        end
        checked++;
      end
      if (s_tvalid && s_tready) expected_q.push_back(grad_step(s_tuser, s_tdata));
      if (cfg_we) begin
        case (cfg_index)
          REG_GAMMA:     gamma_r  = longint'($signed(cfg_wdata[DATA_WIDTH-1:0]));
          REG_MEAN:      mean_r   = longint'($signed(cfg_wdata[DATA_WIDTH-1:0]));
          REG_INV_STD:   rstd_r   = longint'(cfg_wdata[INV_STD_W-1:0]);
          REG_INV_COUNT: rcount_r = longint'(cfg_wdata[INV_CNT_W-1:0]);
          default: ;
        endcase
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the batch-norm backward channel block: stimulus, idling and verdict.
module tb;
  import bnb_pkg::*;

  localparam int DW    = 16;
  localparam int AW    = 48;
  localparam int S_W   = ((2*DW+7)/8)*8;
  localparam int M_W   = ((GIN_W+2*AW+7)/8)*8;
  localparam int CFG_W = (DW > INV_CNT_W) ? DW : INV_CNT_W;

  // The fourth command code is not defined; the block must answer it without
  // touching the sums.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] Q_MAX = ~Q_MIN;
  localparam logic [INV_CNT_W-1:0] COUNT_ONE = 25'd16777216;
  localparam logic [INV_CNT_W-1:0] COUNT_MAX = '1;

  // Random part: phases of well-formed clear/accumulate/emit runs mixed with runs of
  // arbitrary commands, each phase under a fresh channel setting.
  localparam int NUM_PHASES       = 15;
  localparam int ITEMS_PER_PHASE  = 80;
  // The final drain waits longer than an accumulate beat takes to be answered.
  localparam int DRAIN_CYCLES     = 48;
  // The receiver stops taking results for a long stretch once, at this beat.
  localparam int HOLD_AT_BEAT     = 200;
  localparam int HOLD_CYCLES      = 500;
  localparam int CYCLE_LIMIT      = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_W-1:0]       s_tdata   = '0;
  logic [CMD_W-1:0]     s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_W-1:0]       m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int unsigned outstanding, mismatches, checked;

  // Idling modes of the two sides; a set flag means back-to-back beats.
  bit send_eager = 1'b0;
  bit recv_eager = 1'b0;

  int unsigned n_items, n_clear, n_accum, n_emit, n_reserved, n_writes, n_settings;
  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  batch_norm_backward_channel_top #(
    .DATA_WIDTH(DW),
    .ACC_WIDTH (AW)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  bnb_checker #(
    .DATA_WIDTH(DW),
    .ACC_WIDTH (AW)
  ) grad_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .outstanding(outstanding),
    .mismatches (mismatches),
    .checked    (checked)
  );

  // Idle cycles before the next beat on either side. Roughly a third of the
  // beats go without a gap; for the rest the gap is drawn at random and may be none.
  function automatic int unsigned idle_cycles(bit eager);
    if (eager) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // A Q8.8 value that lands on the extremes, on small magnitudes or anywhere.
  function automatic logic [DW-1:0] pick_q88();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return '1;
      4:       return DW'($urandom_range(0, 511) - 256);
      default: return DW'($urandom());
    endcase
  endfunction

  // Register data with random bits above the register's width, which the block
  // has to ignore.
  function automatic logic [CFG_W-1:0] with_junk(logic [DW-1:0] v);
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom());
    w[DW-1:0] = v;
    return w;
  endfunction

  // One register write, followed by a quiet cycle so that the write enable is
  // never lowered and raised in the same step.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // Loads a complete channel setting. Only called while no beat is in flight.
  task automatic set_channel(input logic [DW-1:0] g, input logic [DW-1:0] mu,
                             input logic [INV_STD_W-1:0] rs,
                             input logic [INV_CNT_W-1:0] rc);
    write_reg(REG_GAMMA, with_junk(g));
    write_reg(REG_MEAN, with_junk(mu));
    write_reg(REG_INV_STD, with_junk(rs));
    write_reg(REG_INV_COUNT, CFG_W'(rc));
    n_settings++;
  endtask

  // Offers one beat after a random gap and returns at the edge where it is taken.
  // The valid stays high on return, so a following beat with no gap goes out
  // back to back.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DW-1:0] dout,
                           input logic [DW-1:0] xin);
    int unsigned gap;
    gap = idle_cycles(send_eager);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_W'({xin, dout});
    do @(posedge clk); while (!s_tready);
    case (cmd)
      CMD_CLEAR: n_clear++;
      CMD_ACCUM: n_accum++;
      CMD_EMIT:  n_emit++;
      default:   n_reserved++;
    endcase
    // Reserved beats change nothing, so they do not count toward the item budget.
    if (cmd != CMD_RESERVED) n_items++;
  endtask

  // Drops the valid and waits until every predicted result beat has been seen.
  // The first edge lets the checker's count catch up with a beat taken just now.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One clear, a run of accumulates and then emits that revisit the same
  // (dout, x) pairs, as a real backward pass over a channel would.
  task automatic channel_pass();
    logic [DW-1:0] pd[8];
    logic [DW-1:0] px[8];
    int unsigned n, j;
    n = $urandom_range(1, 8);
    send_beat(CMD_CLEAR, pick_q88(), pick_q88());
    for (int i = 0; i < n; i++) begin
      pd[i] = pick_q88();
      px[i] = pick_q88();
      send_beat(CMD_ACCUM, pd[i], px[i]);
    end
    for (int i = 0; i < n; i++) begin
      j = (i < n && $urandom_range(0, 1) == 0) ? i : $urandom_range(0, n-1);
      send_beat(CMD_EMIT, pd[j], px[j]);
    end
  endtask

  // Receiver: random stalls before each result beat unless it runs eager, with one
  // long hold-off that lets the block fill up and push back on the sender.
  initial begin
    int unsigned w;
    int unsigned taken;
    taken = 0;
    @(negedge rst);
    forever begin
      w = (taken == HOLD_AT_BEAT) ? HOLD_CYCLES : idle_cycles(recv_eager);
      if (w != 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Watchdog: reaching the cycle limit, as a hung handshake would, fails the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: no progress after %0d cycles, %0d results outstanding",
               cycle_count, outstanding);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Stimulus: a directed part on the reset setting and on the extreme settings,
  // then random phases, each under a new channel setting.
  initial begin
    logic [INV_STD_W-1:0] rs;
    logic [INV_CNT_W-1:0] rc;
    int unsigned phase_end;
    n_items    = 0;
    n_clear    = 0;
    n_accum    = 0;
    n_emit     = 0;
    n_reserved = 0;
    n_writes   = 0;
    n_settings = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: gamma 1.0, mean 0, rstd 1.0, 1/count 1.0. The first emit
    // runs on sums that are still zero from reset.
    send_beat(CMD_EMIT, Q_MAX, Q_MIN);
    send_beat(CMD_ACCUM, Q_MAX, Q_MAX);
    send_beat(CMD_ACCUM, Q_MIN, Q_MIN);
    send_beat(CMD_ACCUM, Q_MIN, Q_MAX);
    send_beat(CMD_ACCUM, Q_MAX, Q_MIN);
    send_beat(CMD_ACCUM, '0, '0);
    send_beat(CMD_EMIT, Q_MAX, Q_MAX);
    send_beat(CMD_EMIT, Q_MIN, Q_MIN);
    send_beat(CMD_RESERVED, DW'($urandom()), DW'($urandom()));
    send_beat(CMD_EMIT, 16'h0001, '1);
    send_beat(CMD_CLEAR, Q_MAX, Q_MAX);
    send_beat(CMD_EMIT, '1, 16'h0001);

    // Largest magnitudes everywhere, with 1/count past 1.0: the emit products of the
    // centered sum saturate and grad_in hits its 32-bit clamp.
    wait_idle();
    set_channel(Q_MIN, Q_MAX, '1, COUNT_MAX);
    send_beat(CMD_ACCUM, Q_MIN, Q_MIN);
    send_beat(CMD_ACCUM, Q_MIN, Q_MIN);
    send_beat(CMD_ACCUM, Q_MAX, Q_MIN);
    send_beat(CMD_EMIT, Q_MIN, Q_MIN);
    send_beat(CMD_EMIT, Q_MAX, Q_MAX);
    send_beat(CMD_RESERVED, Q_MAX, Q_MIN);

    // Zero rstd and zero 1/count: every term scaled by rstd or 1/count vanishes.
    wait_idle();
    set_channel(Q_MAX, Q_MIN, '0, '0);
    send_beat(CMD_ACCUM, Q_MAX, Q_MAX);
    send_beat(CMD_EMIT, Q_MAX, Q_MIN);
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_EMIT, Q_MIN, Q_MAX);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       rs = '0;
        1:       rs = '1;
        2:       rs = INV_STD_W'(INV_STD_RESET);
        default: rs = INV_STD_W'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0:       rc = '0;
        1:       rc = COUNT_ONE;
        2:       rc = COUNT_MAX;
        3:       rc = INV_CNT_W'(COUNT_ONE / $urandom_range(1, 4096));
        default: rc = INV_CNT_W'($urandom());
      endcase
      set_channel(pick_q88(), pick_q88(), rs, rc);
      // In about one phase in four, each side on its own runs without any gaps.
      send_eager = ($urandom_range(0, 3) == 0);
      recv_eager = ($urandom_range(0, 3) == 0);
      phase_end = n_items + ITEMS_PER_PHASE;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 3) != 0) begin
          channel_pass();
        end else begin
          // Noise: arbitrary commands, the reserved code among them.
          repeat ($urandom_range(1, 6))
            send_beat(CMD_W'($urandom_range(0, 3)), pick_q88(), pick_q88());
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d beats (%0d clear, %0d accumulate, %0d emit, %0d reserved), %0d results",
             n_items + n_reserved, n_clear, n_accum, n_emit, n_reserved, checked);
    $display("tb: %0d channel settings in %0d register writes, %0d mismatches",
             n_settings, n_writes, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
